FILE: rtl/tvm_pkg.sv
// tvm_pkg: shared types and constants for the timestamped variance matcher
// used by tvm_history and timestamped_variance_matcher_core; no dependencies
package tvm_pkg;

  localparam int NUM_VARS = 6;
  localparam int VAR_W    = 31;
  localparam int STAMP_W  = 63;
  localparam int CFG_W    = 31;

  typedef logic [NUM_VARS-1:0][VAR_W-1:0] var_row_t;
  typedef logic [STAMP_W-1:0]             stamp_t;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_MATCHED  = 2'd2,
    ST_FALLBACK = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_LOAD,
    S_DONE
  } state_t;

  localparam logic       REQ_STORE = 1'b0;
  localparam logic       REQ_QUERY = 1'b1;

  localparam logic [1:0] REG_MAX_AGE  = 2'd0;
  localparam logic [1:0] REG_FLOOR    = 2'd1;
  localparam logic [1:0] REG_EXT_EN   = 2'd2;

  localparam logic [CFG_W-1:0] MAX_AGE_RESET = 31'd100000;
  localparam logic [CFG_W-1:0] FLOOR_RESET   = 31'd655;

endpackage

FILE: rtl/tvm_history.sv
// tvm_history: stamp memory and variance row memory of the sample history
// one write port, one registered read port each; depends on tvm_pkg
module tvm_history #(
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  tvm_pkg::stamp_t   wr_stamp,
  input  tvm_pkg::var_row_t wr_row,
  input  logic [AW-1:0]     stamp_rd_addr,
  output tvm_pkg::stamp_t   stamp_rd,
  input  logic [AW-1:0]     row_rd_addr,
  output tvm_pkg::var_row_t row_rd
);
  import tvm_pkg::*;

  stamp_t   stamp_mem [DEPTH];
  var_row_t row_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      row_mem[wr_addr]   <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    stamp_rd <= stamp_mem[stamp_rd_addr];
    row_rd   <= row_mem[row_rd_addr];
  end

endmodule

FILE: rtl/timestamped_variance_matcher_core.sv
// timestamped_variance_matcher_core: top level of the variance matcher
// depends on tvm_pkg and tvm_history
//
// Requests arrive on the in_ channel (valid/stall). A store request appends
// six non-negative variances and its stamp to a circular history of DEPTH
// entries, overwriting the oldest when full; a bad sample is dropped. A
// query request scans the stored stamps oldest first for the smallest
// absolute difference within max_age_us and takes that entry's variances,
// or its own fallback variances otherwise; the six are reordered to
// north/east/down/roll/pitch/yaw and floored at floor_squared.
// One result per request leaves on the out_ channel from an output register.
// A store, or a query on an empty or disabled history, passes through
// dispatch and done to the output register; a scanning query passes
// dispatch, scan, drain, fetch, load on a match, and done, as the scan
// reads one stamp per cycle from the single read port of the stamp memory.
// One request is in work at a time; the next is taken once the previous
// result is in the output register, even while that result is stalled.
// Reset empties the history (pointer and count cleared, no memory sweep)
// and loads the register defaults. A stalled output holds its result and
// the block waits with in_stall high until it can be replaced.
module timestamped_variance_matcher_core #(
  parameter int DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [62:0]               in_sample_time,
  input  logic signed [31:0]        in_var_x,
  input  logic signed [31:0]        in_var_y,
  input  logic signed [31:0]        in_var_z,
  input  logic signed [31:0]        in_var_rx,
  input  logic signed [31:0]        in_var_ry,
  input  logic signed [31:0]        in_var_rz,
  input  logic                      in_not_finite,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [30:0]               out_var_north,
  output logic [30:0]               out_var_east,
  output logic [30:0]               out_var_down,
  output logic [30:0]               out_var_roll,
  output logic [30:0]               out_var_pitch,
  output logic [30:0]               out_var_yaw,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import tvm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // configuration
  logic [CFG_W-1:0] max_age_r;
  logic [CFG_W-1:0] floor_r;
  logic             ext_en_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= MAX_AGE_RESET;
      floor_r   <= FLOOR_RESET;
      ext_en_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_AGE: max_age_r <= pwdata[CFG_W-1:0];
        REG_FLOOR:   floor_r   <= pwdata[CFG_W-1:0];
        REG_EXT_EN:  ext_en_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_AGE: prdata = {1'b0, max_age_r};
      REG_FLOOR:   prdata = {1'b0, floor_r};
      REG_EXT_EN:  prdata = {31'd0, ext_en_r};
      default:     prdata = 32'd0;
    endcase
  end

  // state machine
  state_t state_r, state_nxt;

  logic                     req_type_r;
  stamp_t                   req_time_r;
  logic signed [31:0]       req_var_r [NUM_VARS];
  logic                     req_nf_r;

  logic [AW-1:0]  wp_r;
  logic [CW-1:0]  cnt_r;
  logic [AW-1:0]  rd_addr_r;
  logic [CW-1:0]  k_r;
  logic           pend_r;
  logic [AW-1:0]  pend_idx_r;
  logic [AW-1:0]  best_r;
  logic [31:0]    best_dt_r;
  logic           found_r;

  status_t            res_status_r;
  logic               res_zero_r;
  logic signed [31:0] res_src_r [NUM_VARS];

  logic               out_valid_r;
  status_t            out_status_r;
  logic [VAR_W-1:0]   out_var_r [NUM_VARS];

  logic     in_acc;
  logic     out_free;
  logic     bad;
  logic     do_write;
  logic     scan_go;
  logic     issue;
  logic     set_fallback;
  logic     set_match;
  logic     load_out;
  logic [SW-1:0] start_sum;
  logic [AW-1:0] start_addr;

  stamp_t   stamp_rd;
  var_row_t row_rd;
  var_row_t wr_row;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    bad = req_nf_r;
    for (int i = 0; i < NUM_VARS; i++) begin
      if (req_var_r[i] < 0) bad = 1'b1;
      wr_row[i] = req_var_r[i][VAR_W-1:0];
    end
  end

  // oldest entry sits count places behind the write pointer
  always_comb begin
    start_sum = SW'(wp_r) + SW'(DEPTH) - SW'(cnt_r);
    if (start_sum >= SW'(DEPTH)) start_sum = start_sum - SW'(DEPTH);
    start_addr = start_sum[AW-1:0];
  end

  always_comb begin
    state_nxt    = state_r;
    do_write     = 1'b0;
    scan_go      = 1'b0;
    issue        = 1'b0;
    set_fallback = 1'b0;
    set_match    = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (req_type_r == REQ_STORE) begin
          do_write  = !bad;
          state_nxt = S_DONE;
        end else if (ext_en_r && (cnt_r != '0)) begin
          scan_go   = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          set_fallback = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (k_r == cnt_r - CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (found_r) begin
          state_nxt = S_LOAD;
        end else begin
          set_fallback = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_LOAD: begin
        set_match = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r   <= in_req_type;
      req_time_r   <= in_sample_time;
      req_nf_r     <= in_not_finite;
      req_var_r[0] <= in_var_x;
      req_var_r[1] <= in_var_y;
      req_var_r[2] <= in_var_z;
      req_var_r[3] <= in_var_rx;
      req_var_r[4] <= in_var_ry;
      req_var_r[5] <= in_var_rz;
    end
  end

  // history pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (do_write) begin
      wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
      if (cnt_r != FULL_CNT) cnt_r <= cnt_r + CW'(1);
    end
  end

  tvm_history #(.DEPTH(DEPTH)) u_history (
    .clk           (clk),
    .wr_en         (do_write),
    .wr_addr       (wp_r),
    .wr_stamp      (req_time_r),
    .wr_row        (wr_row),
    .stamp_rd_addr (rd_addr_r),
    .stamp_rd      (stamp_rd),
    .row_rd_addr   (best_r),
    .row_rd        (row_rd)
  );

  // nearest-stamp compare on the registered read data
  logic [63:0] d_fwd, d_rev;
  logic [62:0] dt;
  logic        closer;

  always_comb begin
    d_fwd  = {1'b0, stamp_rd} - {1'b0, req_time_r};
    d_rev  = {1'b0, req_time_r} - {1'b0, stamp_rd};
    dt     = d_fwd[63] ? d_rev[62:0] : d_fwd[62:0];
    // strict less keeps the oldest entry on a tie
    closer = (dt[62:32] == '0) && (dt[31:0] < best_dt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (scan_go) found_r <= 1'b0;
      else if (pend_r && closer) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      rd_addr_r <= start_addr;
      k_r       <= '0;
      best_dt_r <= {1'b0, max_age_r} + 32'd1;
    end else begin
      if (issue) begin
        rd_addr_r <= (rd_addr_r == LAST_ADDR) ? '0 : rd_addr_r + AW'(1);
        k_r       <= k_r + CW'(1);
      end
      if (pend_r && closer) begin
        best_dt_r <= dt[31:0];
        best_r    <= pend_idx_r;
      end
    end
    pend_idx_r <= rd_addr_r;
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (state_r == S_DISPATCH && req_type_r == REQ_STORE) begin
      res_status_r <= bad ? ST_DROPPED : ST_STORED;
      res_zero_r   <= 1'b1;
    end else if (set_fallback) begin
      res_status_r <= ST_FALLBACK;
      res_zero_r   <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) res_src_r[i] <= req_var_r[i];
    end else if (set_match) begin
      res_status_r <= ST_MATCHED;
      res_zero_r   <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) res_src_r[i] <= {1'b0, row_rd[i]};
    end
  end

  // reorder from enu to north/east/down/roll/pitch/yaw and apply the floor
  logic signed [31:0] ord [NUM_VARS];
  logic [VAR_W-1:0]   floored [NUM_VARS];

  always_comb begin
    ord[0] = res_src_r[1];
    ord[1] = res_src_r[0];
    ord[2] = res_src_r[2];
    ord[3] = res_src_r[4];
    ord[4] = res_src_r[3];
    ord[5] = res_src_r[5];
    for (int i = 0; i < NUM_VARS; i++) begin
      if (res_zero_r) floored[i] = '0;
      else if (ord[i] > $signed({1'b0, floor_r})) floored[i] = ord[i][VAR_W-1:0];
      else floored[i] = floor_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      for (int i = 0; i < NUM_VARS; i++) out_var_r[i] <= floored[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_var_north = out_var_r[0];
  assign out_var_east  = out_var_r[1];
  assign out_var_down  = out_var_r[2];
  assign out_var_roll  = out_var_r[3];
  assign out_var_pitch = out_var_r[4];
  assign out_var_yaw   = out_var_r[5];

endmodule
